>>> hdl/dsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dsf_pkg;

  localparam int unsigned FRAME_LENGTH_DEF = 32;
  localparam int unsigned RECORD_LIMIT_DEF = 600;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 80;

  localparam logic [7:0] PREFIX_FIRST  = 8'h42;
  localparam logic [7:0] PREFIX_SECOND = 8'h4D;
  localparam logic [15:0] PREFIX_SUM   = 16'h008F;

  // reading bytes inside the frame, compared on a 6-bit position
  localparam logic [5:0] PM_HIGH_POS = 6'd12;
  localparam logic [5:0] PM_LOW_POS  = 6'd13;

  localparam logic [15:0] SMART_LEVEL_RST      = 16'd75;
  localparam logic [15:0] WORK_INTERVAL_RST    = 16'd40;
  localparam logic [15:0] DELAY_ON_PERIOD_RST  = 16'd180;
  localparam logic [15:0] DELAY_OFF_PERIOD_RST = 16'd120;
  localparam logic [15:0] FAN_PERIOD_RST       = 16'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMART_LEVEL      = 3'd0,
    REG_WORK_INTERVAL    = 3'd1,
    REG_DELAY_ON_PERIOD  = 3'd2,
    REG_DELAY_OFF_PERIOD = 3'd3,
    REG_FAN_PERIOD       = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_FAN_ON = 2'd1,
    MODE_JUDGE  = 2'd2
  } mode_e;

  localparam logic [1:0] TIMER_NONE  = 2'd0;
  localparam logic [1:0] TIMER_START = 2'd1;
  localparam logic [1:0] TIMER_STOP  = 2'd2;

  localparam logic [1:0] FAN_NONE  = 2'd0;
  localparam logic [1:0] FAN_START = 2'd1;
  localparam logic [1:0] FAN_STOP  = 2'd2;

  typedef struct packed {
    logic load;
    logic div_start;
    logic eval;
    logic commit;
  } dsf_cmd_t;

  typedef struct packed {
    logic div_done;
  } dsf_status_t;

  typedef struct packed {
    logic [1:0]  smart_mode;
    logic        average_invalid;
    logic [15:0] average_level;
    logic [15:0] fan_step_period;
    logic [1:0]  fan_command;
    logic        measure_stop;
    logic [15:0] timer_period;
    logic [1:0]  timer_command;
    logic        display_update;
    logic [15:0] pm25_value;
    logic        checksum_ok;
    logic        frame_done;
  } dsf_result_t;

endpackage
`default_nettype wire

>>> hdl/dsf_div.sv
`timescale 1ns / 1ps
`default_nettype none
module dsf_div #(
  parameter int unsigned NUM_W = 26,
  parameter int unsigned DEN_W = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [NUM_W-1:0] quo_q, quo_d;

  logic [DEN_W:0] shifted;
  logic [DEN_W:0] diff;
  logic           ge;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = ~diff[DEN_W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

>>> hdl/dsf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module dsf_datapath
  import dsf_pkg::*;
#(
  parameter int unsigned FRAME_LENGTH = FRAME_LENGTH_DEF,
  parameter int unsigned RECORD_LIMIT = RECORD_LIMIT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_func_i,
  input  wire logic [7:0]            in_byte_i,
  input  wire dsf_cmd_t              cmd_i,
  output dsf_status_t                status_o,
  output dsf_result_t                result_o
);

  localparam int unsigned POS_W = $clog2(FRAME_LENGTH);
  localparam int unsigned CNT_W = $clog2(RECORD_LIMIT + 1);
  localparam int unsigned SUM_W = 16 + CNT_W;
  localparam logic [POS_W-1:0] POS_CHK_HIGH = POS_W'(FRAME_LENGTH - 2);
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_LENGTH - 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT    = CNT_W'(RECORD_LIMIT);

  // configuration
  logic [15:0] smart_level_q, work_interval_q, delay_on_q, delay_off_q, fan_period_q;

  // captured request
  logic       func_q;
  logic [7:0] byte_q;

  // parser and decision state
  logic             prefix_q, prefix_d;
  logic             in_frame_q, in_frame_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      csum_q, csum_d;
  logic [7:0]       chk_high_q, chk_high_d;
  logic [7:0]       rd_high_q, rd_high_d;
  logic [7:0]       rd_low_q, rd_low_d;
  logic [15:0]      latest_q, latest_d;
  logic [15:0]      work_cnt_q, work_cnt_d;
  mode_e            mode_q, mode_d;
  logic [SUM_W-1:0] rec_sum_q, rec_sum_d;
  logic [CNT_W-1:0] rec_cnt_q, rec_cnt_d;
  logic [1:0]       disp_cnt_q, disp_cnt_d;

  // flags registered in the evaluate step, ahead of commit
  logic        chk_ok_q;
  logic        run_q;
  logic        pm_lt_q;
  logic        pm_gt_q;
  logic        rec_room_q;
  logic [15:0] pm_q;

  dsf_result_t res_q, res_d;

  logic             div_done;
  logic [SUM_W-1:0] div_quot;
  logic [15:0]      avg;
  logic [5:0]       pos_ext;
  logic [7:0]       pm_high_now;
  logic [7:0]       pm_low_now;
  logic [15:0]      pm_now;

  dsf_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (rec_sum_q),
    .den_i  (rec_cnt_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign status_o.div_done = div_done;
  assign avg     = (rec_cnt_q == '0) ? 16'd0 : div_quot[15:0];
  assign pos_ext = 6'(pos_q);

  // a short frame can end on a reading byte, so take it from the request itself
  assign pm_high_now = (pos_ext == PM_HIGH_POS) ? byte_q : rd_high_q;
  assign pm_low_now  = (pos_ext == PM_LOW_POS) ? byte_q : rd_low_q;
  assign pm_now      = {pm_high_now, pm_low_now};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smart_level_q   <= SMART_LEVEL_RST;
      work_interval_q <= WORK_INTERVAL_RST;
      delay_on_q      <= DELAY_ON_PERIOD_RST;
      delay_off_q     <= DELAY_OFF_PERIOD_RST;
      fan_period_q    <= FAN_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SMART_LEVEL:      smart_level_q   <= cfg_data_i;
        REG_WORK_INTERVAL:    work_interval_q <= cfg_data_i;
        REG_DELAY_ON_PERIOD:  delay_on_q      <= cfg_data_i;
        REG_DELAY_OFF_PERIOD: delay_off_q     <= cfg_data_i;
        REG_FAN_PERIOD:       fan_period_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_func_i;
      byte_q <= in_byte_i;
    end
    if (cmd_i.eval) begin
      pm_q       <= pm_now;
      chk_ok_q   <= ({chk_high_q, byte_q} == csum_q);
      run_q      <= (work_cnt_q >= work_interval_q) || (mode_q != MODE_IDLE);
      pm_lt_q    <= (pm_now < smart_level_q);
      pm_gt_q    <= (pm_now > smart_level_q);
      rec_room_q <= (rec_cnt_q < CNT_LIMIT);
    end
    res_q <= res_d;
  end

  always_comb begin
    prefix_d   = prefix_q;
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    csum_d     = csum_q;
    chk_high_d = chk_high_q;
    rd_high_d  = rd_high_q;
    rd_low_d   = rd_low_q;
    latest_d   = latest_q;
    work_cnt_d = work_cnt_q;
    mode_d     = mode_q;
    rec_sum_d  = rec_sum_q;
    rec_cnt_d  = rec_cnt_q;
    disp_cnt_d = disp_cnt_q;
    res_d      = res_q;

    if (cmd_i.commit) begin
      res_d = '0;
      if (func_q) begin
        // timer expiry: judge the recorded average
        res_d.average_level   = avg;
        res_d.average_invalid = (rec_cnt_q == '0);
        rec_sum_d = '0;
        rec_cnt_d = '0;
        if (avg > smart_level_q) begin
          res_d.fan_command     = FAN_START;
          res_d.fan_step_period = fan_period_q;
          mode_d = MODE_FAN_ON;
        end else begin
          res_d.timer_command = TIMER_STOP;
          res_d.fan_command   = FAN_STOP;
          mode_d = MODE_IDLE;
        end
      end else if (!in_frame_q) begin
        // prefix hunt, a failing byte is not retried as a first byte
        if (!prefix_q) begin
          prefix_d = (byte_q == PREFIX_FIRST);
        end else if (byte_q == PREFIX_SECOND) begin
          prefix_d   = 1'b0;
          in_frame_d = 1'b1;
          pos_d      = POS_W'(2);
          csum_d     = PREFIX_SUM;
          rd_high_d  = '0;
          rd_low_d   = '0;
          chk_high_d = '0;
        end else begin
          prefix_d = 1'b0;
        end
      end else begin
        if (pos_q < POS_CHK_HIGH) begin
          csum_d = csum_q + 16'(byte_q);
        end
        if (pos_ext == PM_HIGH_POS) begin
          rd_high_d = byte_q;
        end
        if (pos_ext == PM_LOW_POS) begin
          rd_low_d = byte_q;
        end
        if (pos_q == POS_CHK_HIGH) begin
          chk_high_d = byte_q;
        end
        if (pos_q >= POS_LAST) begin
          in_frame_d        = 1'b0;
          pos_d             = '0;
          res_d.frame_done  = 1'b1;
          if (chk_ok_q) begin
            res_d.checksum_ok = 1'b1;
            latest_d          = pm_q;
            work_cnt_d        = run_q ? 16'd0 : work_cnt_q + 16'd1;
            if (run_q) begin
              if (mode_q == MODE_FAN_ON && pm_lt_q) begin
                mode_d              = MODE_JUDGE;
                res_d.timer_command = TIMER_START;
                res_d.timer_period  = delay_off_q;
                res_d.measure_stop  = 1'b1;
              end else if (mode_q == MODE_IDLE && pm_gt_q) begin
                mode_d              = MODE_JUDGE;
                res_d.timer_command = TIMER_START;
                res_d.timer_period  = delay_on_q;
              end
              if (mode_d == MODE_JUDGE && rec_room_q) begin
                rec_sum_d = rec_sum_q + SUM_W'(pm_q);
                rec_cnt_d = rec_cnt_q + CNT_W'(1);
              end
            end
            // first update on the fourth good frame, then every third
            if (disp_cnt_q == 2'd3) begin
              res_d.display_update = 1'b1;
              disp_cnt_d = 2'd1;
            end else begin
              disp_cnt_d = disp_cnt_q + 2'd1;
            end
          end
        end else begin
          pos_d = pos_q + POS_W'(1);
        end
      end
      res_d.pm25_value = latest_d;
      res_d.smart_mode = mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q   <= 1'b0;
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      csum_q     <= '0;
      chk_high_q <= '0;
      rd_high_q  <= '0;
      rd_low_q   <= '0;
      latest_q   <= '0;
      work_cnt_q <= '0;
      mode_q     <= MODE_IDLE;
      rec_sum_q  <= '0;
      rec_cnt_q  <= '0;
      disp_cnt_q <= '0;
    end else begin
      prefix_q   <= prefix_d;
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      csum_q     <= csum_d;
      chk_high_q <= chk_high_d;
      rd_high_q  <= rd_high_d;
      rd_low_q   <= rd_low_d;
      latest_q   <= latest_d;
      work_cnt_q <= work_cnt_d;
      mode_q     <= mode_d;
      rec_sum_q  <= rec_sum_d;
      rec_cnt_q  <= rec_cnt_d;
      disp_cnt_q <= disp_cnt_d;
    end
  end

  assign result_o = res_q;

endmodule
`default_nettype wire

>>> hdl/dsf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module dsf_ctrl
  import dsf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  input  wire logic        s_func_i,
  output logic             s_ready_o,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  input  wire dsf_status_t status_i,
  output dsf_cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_COMMIT
  } state_e;

  state_e state_q;
  logic   m_valid_q;
  logic   accept;
  logic   out_free;
  logic   commit;

  // the result register frees up in the same cycle it is taken
  assign out_free = ~m_valid_q | m_ready_i;
  assign accept   = s_valid_i & (state_q == S_IDLE);
  assign commit   = (state_q == S_COMMIT) & out_free;

  assign cmd_o.load      = accept;
  assign cmd_o.div_start = accept & s_func_i;
  assign cmd_o.eval      = (state_q == S_EVAL);
  assign cmd_o.commit    = commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= commit | (m_valid_q & ~m_ready_i);
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= s_func_i ? S_DIV : S_EVAL;
          end
        end
        S_EVAL: begin
          state_q <= S_COMMIT;
        end
        S_DIV: begin
          if (status_i.div_done) begin
            state_q <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;

endmodule
`default_nettype wire

>>> hdl/dust_sensor_frame_smart_fan.sv
`timescale 1ns / 1ps
`default_nettype none
// Dust sensor frame parser with smart fan decision. Each input request is either a sensor
// byte (tuser low) or a delay timer expiry (tuser high) and yields exactly one result.
// Bytes hunt for the 0x42 0x4D prefix, then collect a frame of FRAME_LENGTH bytes whose
// 16-bit sum is checked against its last two bytes; a good frame updates the PM2.5 reading
// and the idle / fan on / judging decision, recording readings (up to RECORD_LIMIT) while
// judging. An expiry divides the recorded sum by the count and decides the fan; an empty
// record gives average 0 with average_invalid set. A byte goes through accept, evaluate and
// commit before its result is registered; an expiry goes through accept, the bit-serial
// divider that yields one quotient bit per cycle, and commit. One request is in work at a
// time; the next is accepted while the previous result waits in the output register.
// Configuration writes are taken at any time.
module dust_sensor_frame_smart_fan
  import dsf_pkg::*;
#(
  parameter int unsigned FRAME_LENGTH = FRAME_LENGTH_DEF,
  parameter int unsigned RECORD_LIMIT = RECORD_LIMIT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // rx_byte
  input  wire logic                  s_axis_tuser,   // func
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // frame_done, checksum_ok, pm25_value, display_update, timer_command, timer_period,
  // measure_stop, fan_command, fan_step_period, average_level, average_invalid,
  // smart_mode, zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  dsf_cmd_t    cmd;
  dsf_status_t status;
  dsf_result_t res;

  dsf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_func_i (s_axis_tuser),
    .s_ready_o(s_axis_tready),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .status_i (status),
    .cmd_o    (cmd)
  );

  dsf_datapath #(
    .FRAME_LENGTH(FRAME_LENGTH),
    .RECORD_LIMIT(RECORD_LIMIT)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_func_i (s_axis_tuser),
    .in_byte_i (s_axis_tdata),
    .cmd_i     (cmd),
    .status_o  (status),
    .result_o  (res)
  );

  assign m_axis_tdata = {5'b0, res.smart_mode, res.average_invalid, res.average_level,
                         res.fan_step_period, res.fan_command, res.measure_stop,
                         res.timer_period, res.timer_command, res.display_update,
                         res.pm25_value, res.checksum_ok, res.frame_done};

endmodule
`default_nettype wire

>>> bench/dust_sensor_frame_smart_fan_tb.sv
`timescale 1ns / 1ps
module dust_sensor_frame_smart_fan_tb;
  import dsf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned FL = FRAME_LENGTH_DEF;

  typedef struct packed {
    logic        func;
    logic [7:0]  rx;
    logic        typed;
    dsf_result_t want;
  } probe_row_t;

  localparam dsf_result_t QUIET = '0;
  localparam dsf_result_t EXPIRY_EMPTY = '{smart_mode: MODE_IDLE, average_invalid: 1'b1,
                                           timer_command: TIMER_STOP, fan_command: FAN_STOP,
                                           default: '0};

  // reset-state probes: prefix hunting and empty expiries only, so every result is known
  localparam probe_row_t PROBE_ROWS [14] = '{
    '{1'b1, 8'h00, 1'b1, EXPIRY_EMPTY},
    '{1'b1, 8'hFF, 1'b1, EXPIRY_EMPTY},  // byte ignored on expiry
    '{1'b0, 8'h00, 1'b1, QUIET},
    '{1'b0, 8'hFF, 1'b1, QUIET},
    '{1'b0, 8'h4D, 1'b1, QUIET},         // second prefix byte alone
    '{1'b0, 8'h42, 1'b1, QUIET},
    '{1'b0, 8'h42, 1'b1, QUIET},         // mismatch clears, not taken as a new first byte
    '{1'b0, 8'h4D, 1'b1, QUIET},
    '{1'b0, 8'h42, 1'b1, QUIET},
    '{1'b0, 8'h00, 1'b1, QUIET},
    '{1'b0, 8'h4D, 1'b1, QUIET},
    '{1'b0, 8'h42, 1'b1, QUIET},
    '{1'b1, 8'h5A, 1'b1, EXPIRY_EMPTY},  // expiry leaves the half-matched prefix alone
    '{1'b0, 8'h00, 1'b1, QUIET}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  dust_sensor_frame_smart_fan dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // predictor copy of the registers
  logic [15:0] thr_level     = SMART_LEVEL_RST;
  logic [15:0] eval_interval = WORK_INTERVAL_RST;
  logic [15:0] on_delay      = DELAY_ON_PERIOD_RST;
  logic [15:0] off_delay     = DELAY_OFF_PERIOD_RST;
  logic [15:0] fan_step      = FAN_PERIOD_RST;

  // predictor copy of the parser and fan decision state
  logic        prefix_hit  = 1'b0;
  logic        collecting  = 1'b0;
  logic [4:0]  pos         = '0;
  logic [15:0] sum_acc     = '0;
  logic [7:0]  chk_high    = '0;
  logic [7:0]  pm_high     = '0;
  logic [7:0]  pm_low      = '0;
  logic [15:0] last_pm     = '0;
  logic [15:0] frame_tally = '0;
  mode_e       fan_mode    = MODE_IDLE;
  logic [25:0] rec_sum     = '0;
  logic [9:0]  rec_cnt     = '0;
  logic [1:0]  disp_cnt    = '0;

  dsf_result_t pending_results[$];
  int unsigned fails = 0;
  int unsigned cycles = 0;
  int unsigned n_requests = 0;
  int unsigned n_good = 0;
  int unsigned n_bad = 0;
  int unsigned n_expiry = 0;
  logic        calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("dust_sensor_frame_smart_fan_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);
  end

  function automatic dsf_result_t predict_event(input logic ev, input logic [7:0] b);
    dsf_result_t r;
    logic        run;
    logic [4:0]  p;
    logic [25:0] quot;
    logic [15:0] avg;
    r = '0;
    if (!ev) begin
      if (!collecting) begin
        if (!prefix_hit) begin
          prefix_hit = (b == PREFIX_FIRST);
        end else if (b == PREFIX_SECOND) begin
          prefix_hit = 1'b0;
          collecting = 1'b1;
          pos = 5'd2;
          sum_acc = PREFIX_SUM;
          pm_high = '0;
          pm_low = '0;
          chk_high = '0;
        end else begin
          prefix_hit = 1'b0;
        end
      end else begin
        p = pos;
        if (p < FL - 2) sum_acc = sum_acc + b;
        if (p == PM_HIGH_POS) pm_high = b;
        if (p == PM_LOW_POS) pm_low = b;
        if (p == FL - 2) chk_high = b;
        if (p >= FL - 1) begin
          collecting = 1'b0;
          pos = '0;
          r.frame_done = 1'b1;
          if ({chk_high, b} == sum_acc) begin
            r.checksum_ok = 1'b1;
            n_good++;
            last_pm = {pm_high, pm_low};
            run = (frame_tally >= eval_interval) || (fan_mode != MODE_IDLE);
            frame_tally = frame_tally + 1'b1;
            if (run) begin
              frame_tally = '0;
              if (fan_mode == MODE_FAN_ON && last_pm < thr_level) begin
                fan_mode = MODE_JUDGE;
                r.timer_command = TIMER_START;
                r.timer_period = off_delay;
                r.measure_stop = 1'b1;
              end else if (fan_mode == MODE_IDLE && last_pm > thr_level) begin
                fan_mode = MODE_JUDGE;
                r.timer_command = TIMER_START;
                r.timer_period = on_delay;
              end
              if (fan_mode == MODE_JUDGE && rec_cnt < RECORD_LIMIT_DEF) begin
                rec_sum = rec_sum + last_pm;
                rec_cnt = rec_cnt + 1'b1;
              end
            end
            if (disp_cnt == 2'd3) begin
              r.display_update = 1'b1;
              disp_cnt = '0;
            end
            disp_cnt = disp_cnt + 1'b1;
          end else begin
            n_bad++;
          end
        end else begin
          pos = p + 1'b1;
        end
      end
    end else begin
      n_expiry++;
      avg = '0;
      if (rec_cnt == '0) begin
        r.average_invalid = 1'b1;
      end else begin
        quot = rec_sum / rec_cnt;
        avg = quot[15:0];
      end
      rec_sum = '0;
      rec_cnt = '0;
      r.average_level = avg;
      if (avg > thr_level) begin
        r.fan_command = FAN_START;
        r.fan_step_period = fan_step;
        fan_mode = MODE_FAN_ON;
      end else begin
        r.timer_command = TIMER_STOP;
        r.fan_command = FAN_STOP;
        fan_mode = MODE_IDLE;
      end
    end
    r.pm25_value = last_pm;
    r.smart_mode = fan_mode;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    dsf_result_t got;
    dsf_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = dsf_result_t'(m_axis_tdata[$bits(dsf_result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: 0x%0h", m_axis_tdata);
        fails++;
      end else begin
        want = pending_results.pop_front();
        check_field("frame_done", want.frame_done, got.frame_done);
        check_field("checksum_ok", want.checksum_ok, got.checksum_ok);
        check_field("pm25_value", want.pm25_value, got.pm25_value);
        check_field("display_update", want.display_update, got.display_update);
        check_field("timer_command", want.timer_command, got.timer_command);
        check_field("timer_period", want.timer_period, got.timer_period);
        check_field("measure_stop", want.measure_stop, got.measure_stop);
        check_field("fan_command", want.fan_command, got.fan_command);
        check_field("fan_step_period", want.fan_step_period, got.fan_step_period);
        check_field("average_level", want.average_level, got.average_level);
        check_field("average_invalid", want.average_invalid, got.average_invalid);
        check_field("smart_mode", want.smart_mode, got.smart_mode);
      end
    end
  end

  // valid stays high between back-to-back requests, it only drops for a gap or in wait_idle
  task automatic send_event(input logic ev, input logic [7:0] rx, input logic typed,
                            input dsf_result_t want);
    dsf_result_t pred;
    if (!calm && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= ev;
    s_axis_tdata <= rx;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_event(ev, rx);
    pending_results.push_back(typed ? want : pred);
    n_requests++;
  endtask

  task automatic send_byte(input logic [7:0] rx);
    send_event(1'b0, rx, 1'b0, QUIET);
  endtask

  task automatic send_expiry();
    send_event(1'b1, 8'($urandom), 1'b0, QUIET);
  endtask

  task automatic send_frame(input logic [15:0] pm, input logic corrupt, input logic cut_in);
    logic [7:0]  fb [FL];
    logic [15:0] sum;
    int          flip;
    int          cut;
    fb[0] = PREFIX_FIRST;
    fb[1] = PREFIX_SECOND;
    for (int i = 2; i < FL - 2; i++) fb[i] = 8'($urandom);
    fb[PM_HIGH_POS] = pm[15:8];
    fb[PM_LOW_POS] = pm[7:0];
    sum = '0;
    for (int i = 0; i < FL - 2; i++) sum = sum + fb[i];
    fb[FL-2] = sum[15:8];
    fb[FL-1] = sum[7:0];
    if (corrupt) begin
      flip = $urandom_range(2, FL - 1);
      fb[flip] = fb[flip] ^ (8'h01 << $urandom_range(0, 7));
    end
    cut = cut_in ? $urandom_range(2, FL - 1) : -1;
    for (int i = 0; i < FL; i++) begin
      if (i == cut) send_expiry();
      send_byte(fb[i]);
    end
  endtask

  function automatic logic [15:0] pick_reading();
    case ($urandom_range(0, 6))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return thr_level - 1'b1;
      3: return thr_level;
      4: return thr_level + 1'b1;
      default: return thr_level + 16'($urandom_range(0, 80)) - 16'd40;
    endcase
  endfunction

  task automatic set_reg(input cfg_reg_e idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_SMART_LEVEL:      thr_level = val;
      REG_WORK_INTERVAL:    eval_interval = val;
      REG_DELAY_ON_PERIOD:  on_delay = val;
      REG_DELAY_OFF_PERIOD: off_delay = val;
      REG_FAN_PERIOD:       fan_step = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] lvl, input logic [15:0] intv,
                                input logic [15:0] on_p, input logic [15:0] off_p,
                                input logic [15:0] fan_p);
    set_reg(REG_SMART_LEVEL, lvl);
    set_reg(REG_WORK_INTERVAL, intv);
    set_reg(REG_DELAY_ON_PERIOD, on_p);
    set_reg(REG_DELAY_OFF_PERIOD, off_p);
    set_reg(REG_FAN_PERIOD, fan_p);
    cfg_we_i <= 1'b0;
  endtask

  // hold the sender until every request has its result back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic run_random(input int n);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_frame(pick_reading(), 1'b0, $urandom_range(0, 9) == 0);
        sent += FL;
      end else if (pick < 72) begin
        send_frame(pick_reading(), 1'b1, 1'b0);
        sent += FL;
      end else if (pick < 85) begin
        send_expiry();
        sent++;
      end else begin
        // line noise and broken prefixes
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++)
          send_byte((k == 0 && $urandom_range(0, 1) == 1) ? PREFIX_FIRST : 8'($urandom));
        sent += len;
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_SMART_LEVEL;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (PROBE_ROWS[i])
      send_event(PROBE_ROWS[i].func, PROBE_ROWS[i].rx, PROBE_ROWS[i].typed, PROBE_ROWS[i].want);
    send_frame(16'hFFFF, 1'b0, 1'b0);
    send_frame(16'h0000, 1'b0, 1'b0);
    send_frame(16'h1234, 1'b1, 1'b0);
    send_expiry();
    wait_idle();

    apply_settings(16'd60, 16'd2, DELAY_ON_PERIOD_RST, DELAY_OFF_PERIOD_RST, FAN_PERIOD_RST);
    run_random(150);
    wait_idle();

    calm = 1'b1;
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(150);
    wait_idle();
    calm = 1'b0;

    // record top-scale readings while judging, then average them on expiry
    apply_settings(16'hFFFE, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_expiry();
    repeat (2) send_frame(16'hFFFF, 1'b0, 1'b0);
    send_expiry();
    run_random(40);
    wait_idle();

    apply_settings(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1);
    run_random(100);
    wait_idle();
    repeat (40) @(posedge clk_i);

    $display("covered %0d requests: %0d good frames, %0d bad frames, %0d timer expiries,",
             n_requests, n_good, n_bad, n_expiry);
    $display("including top-scale readings averaged while judging and extreme register values");
    if (fails == 0) begin
      $display("dust_sensor_frame_smart_fan_tb OK");
    end else begin
      $display("dust_sensor_frame_smart_fan_tb NOT OK");
    end
    $finish;
  end

endmodule
